// ===== design/kptc_pkg.sv =====
// Shared types, constants and helper functions for the knob panel tick controller.
package kptc_pkg;

	localparam int NUM_ENCODERS = 5;
	localparam int NUM_BUTTONS  = 7;
	localparam int IRIS_STOPS   = 25;

	localparam int STEP_W = 2 * NUM_ENCODERS;
	localparam int CHAN_W = 11;
	localparam int CFG_AW = 3;

	// Configuration register indexes
	localparam logic [CFG_AW-1:0] CFG_FOCUS_MIN  = 3'd0;
	localparam logic [CFG_AW-1:0] CFG_FOCUS_MAX  = 3'd1;
	localparam logic [CFG_AW-1:0] CFG_IRIS_LAST  = 3'd2;
	localparam logic [CFG_AW-1:0] CFG_STICK_HIGH = 3'd3;
	localparam logic [CFG_AW-1:0] CFG_STICK_LOW  = 3'd4;
	localparam logic [CFG_AW-1:0] CFG_NEUTRAL    = 3'd5;

	// Step direction codes
	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_CW   = 2'd1;
	localparam logic [1:0] DIR_CCW  = 2'd2;

	// Debouncer state codes
	localparam logic [1:0] DB_IDLE = 2'd0;
	localparam logic [1:0] DB_ARM  = 2'd1;
	localparam logic [1:0] DB_HELD = 2'd2;
	localparam logic [1:0] DB_REL  = 2'd3;

	// Tick phase codes
	localparam logic [1:0] PH_UPDATE = 2'd0;
	localparam logic [1:0] PH_FRAME  = 2'd1;
	localparam logic [1:0] PH_REST   = 2'd2;

	// Encoder assignment
	localparam int ENC_BALANCE = 0;
	localparam int ENC_GAIN    = 1;
	localparam int ENC_SHUTTER = 2;
	localparam int ENC_IRIS    = 3;
	localparam int ENC_FOCUS   = 4;

	localparam logic [4:0]        IRIS_TOP_MAX   = 5'(IRIS_STOPS - 1);
	localparam logic [7:0]        FOCUS_RESET    = 8'd128;
	localparam logic [CHAN_W-1:0] CHAN_RESET     = 11'h400;
	localparam logic [7:0]        FOCUS_MIN_RST  = 8'd44;
	localparam logic [7:0]        FOCUS_MAX_RST  = 8'd212;
	localparam logic [4:0]        IRIS_LAST_RST  = 5'd24;
	localparam logic [CHAN_W-1:0] STICK_HIGH_RST = 11'(8 * 212);
	localparam logic [CHAN_W-1:0] STICK_LOW_RST  = 11'(8 * 44);
	localparam logic [CHAN_W-1:0] NEUTRAL_RST    = 11'h400;
	localparam logic signed [7:0] PEND_MAX       = 8'sd127;
	localparam logic signed [7:0] PEND_MIN       = -8'sd127;

	typedef struct packed {
		logic [NUM_ENCODERS-1:0] enc_a_pins;
		logic [NUM_ENCODERS-1:0] enc_b_pins;
		logic [NUM_BUTTONS-1:0]  button_pins;
	} in_word_t;

	typedef struct packed {
		logic [NUM_BUTTONS-1:0] pressed_mask;
		logic [STEP_W-1:0]      step_dirs;
		logic                   report_needed;
		logic                   frame_due;
		logic [CHAN_W-1:0]      iris_servo;
		logic [CHAN_W-1:0]      focus_servo;
		logic [CHAN_W-1:0]      gain_servo;
		logic [CHAN_W-1:0]      shutter_servo;
		logic [CHAN_W-1:0]      balance_servo;
	} out_word_t;

	// Filtered pin results handed from the pin filter to the top level
	typedef struct packed {
		logic [NUM_BUTTONS-1:0]             pressed;
		logic [NUM_ENCODERS-1:0][1:0]       dirs;
		logic                               report;
	} filt_t;

	typedef struct packed {
		logic [CHAN_W-1:0] chan;
		logic signed [7:0] pend;
	} stick_t;

	// Saturating step accumulate
	function automatic logic signed [7:0] bump(input logic signed [7:0] v,
			input logic [1:0] d);
		logic signed [7:0] r;
		r = v;
		if (d == DIR_CW) begin
			if (v < PEND_MAX) r = v + 8'sd1;
		end else if (d == DIR_CCW) begin
			if (v > PEND_MIN) r = v - 8'sd1;
		end
		return r;
	endfunction

	// One stick pulse per pending step; non-neutral returns to neutral
	function automatic stick_t stick_step(input logic [CHAN_W-1:0] chan,
			input logic signed [7:0] pend, input logic [CHAN_W-1:0] hi,
			input logic [CHAN_W-1:0] lo, input logic [CHAN_W-1:0] neu);
		stick_t r;
		r.chan = chan;
		r.pend = pend;
		if (chan == neu) begin
			if (pend > 8'sd0) begin
				r.chan = hi;
				r.pend = pend - 8'sd1;
			end else if (pend < 8'sd0) begin
				r.chan = lo;
				r.pend = pend + 8'sd1;
			end
		end else begin
			r.chan = neu;
		end
		return r;
	endfunction

	// f-stop table
	function automatic logic [7:0] stop_entry(input logic [4:0] idx);
		logic [7:0] v;
		case (idx)
			5'd0:  v = 8'd212;
			5'd1:  v = 8'd205;
			5'd2:  v = 8'd198;
			5'd3:  v = 8'd191;
			5'd4:  v = 8'd184;
			5'd5:  v = 8'd177;
			5'd6:  v = 8'd170;
			5'd7:  v = 8'd163;
			5'd8:  v = 8'd156;
			5'd9:  v = 8'd149;
			5'd10: v = 8'd142;
			5'd11: v = 8'd135;
			5'd12: v = 8'd128;
			5'd13: v = 8'd121;
			5'd14: v = 8'd115;
			5'd15: v = 8'd107;
			5'd16: v = 8'd100;
			5'd17: v = 8'd93;
			5'd18: v = 8'd86;
			5'd19: v = 8'd80;
			5'd20: v = 8'd73;
			5'd21: v = 8'd66;
			5'd22: v = 8'd60;
			5'd23: v = 8'd56;
			default: v = 8'd44;
		endcase
		return v;
	endfunction

endpackage

// ===== design/kptc_pin_filter.sv =====
// Pin history, quadrature step decode and button debounce for one tick.
module kptc_pin_filter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  kptc_pkg::in_word_t  word,
	output kptc_pkg::filt_t     filt
);

	logic                                 primed_q;
	logic [kptc_pkg::NUM_ENCODERS-1:0][2:0] hist_a_q, hist_b_q;
	logic [kptc_pkg::NUM_ENCODERS-1:0][2:0] hist_a_n, hist_b_n;
	logic [kptc_pkg::NUM_BUTTONS-1:0][1:0]  db_q, db_n;
	logic [kptc_pkg::NUM_BUTTONS-1:0]       last_pressed_q;
	logic [kptc_pkg::NUM_BUTTONS-1:0]       pressed;
	logic [kptc_pkg::NUM_ENCODERS-1:0][1:0] dirs;

	always_comb begin
		for (int i = 0; i < kptc_pkg::NUM_ENCODERS; i++) begin
			// first tick: seed history from the pin so no step shows
			if (primed_q) begin
				hist_a_n[i] = {hist_a_q[i][1:0], word.enc_a_pins[i]};
				hist_b_n[i] = {hist_b_q[i][1:0], word.enc_b_pins[i]};
			end else begin
				hist_a_n[i] = {3{word.enc_a_pins[i]}};
				hist_b_n[i] = {3{word.enc_b_pins[i]}};
			end
			dirs[i] = kptc_pkg::DIR_NONE;
			if (hist_a_n[i] == 3'b100) begin
				dirs[i] = hist_b_n[i][1] ? kptc_pkg::DIR_CW : kptc_pkg::DIR_CCW;
			end else if (hist_a_n[i] == 3'b011) begin
				dirs[i] = hist_b_n[i][1] ? kptc_pkg::DIR_CCW : kptc_pkg::DIR_CW;
			end
		end
		for (int j = 0; j < kptc_pkg::NUM_BUTTONS; j++) begin
			case (db_q[j])
				kptc_pkg::DB_IDLE: db_n[j] = word.button_pins[j] ? kptc_pkg::DB_ARM
						: kptc_pkg::DB_IDLE;
				kptc_pkg::DB_ARM:  db_n[j] = word.button_pins[j] ? kptc_pkg::DB_HELD
						: kptc_pkg::DB_IDLE;
				kptc_pkg::DB_HELD: db_n[j] = word.button_pins[j] ? kptc_pkg::DB_HELD
						: kptc_pkg::DB_REL;
				default:           db_n[j] = word.button_pins[j] ? kptc_pkg::DB_HELD
						: kptc_pkg::DB_IDLE;
			endcase
			pressed[j] = db_n[j][1];
		end
	end

	assign filt.pressed = pressed;
	assign filt.dirs    = dirs;
	assign filt.report  = (|dirs) | (pressed != last_pressed_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q       <= 1'b0;
			hist_a_q       <= '0;
			hist_b_q       <= '0;
			db_q           <= '0;
			last_pressed_q <= '0;
		end else if (advance) begin
			primed_q       <= 1'b1;
			hist_a_q       <= hist_a_n;
			hist_b_q       <= hist_b_n;
			db_q           <= db_n;
			last_pressed_q <= pressed;
		end
	end

endmodule

// ===== design/knob_panel_tick_controller_top.sv =====
// Top level of the knob panel tick controller: input register, tick logic, result register.
//
//   channel  direction  handshake                 word
//   in       in         in_valid / in_ready       in_word  (kptc_pkg::in_word_t)
//   out      out        out_valid / out_ready     out_word (kptc_pkg::out_word_t)
//   cfg      in         cfg_en (no wait)          cfg_addr, cfg_data
//
// One tick word per cycle sustained while out_ready stays high; the result is registered.
// The tick logic runs in one pass between the input register and the result register.
// A stalled result holds in the result register; the input register takes one more word
// behind it, and in_ready drops only when both are full.
// Reset initialises all history, debouncers, pending counts and channels; no clearing pass.
module knob_panel_tick_controller_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  kptc_pkg::in_word_t                     in_word,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output kptc_pkg::out_word_t                    out_word,
	input  logic                                   cfg_en,
	input  logic [kptc_pkg::CFG_AW-1:0]            cfg_addr,
	input  logic [kptc_pkg::CHAN_W-1:0]            cfg_data
);

	logic                         v_s1;
	kptc_pkg::in_word_t           word_s1;
	logic                         advance;
	kptc_pkg::filt_t              filt;

	logic [7:0]                   focus_min_q, focus_max_q;
	logic [4:0]                   iris_last_q;
	logic [kptc_pkg::CHAN_W-1:0]  stick_high_q, stick_low_q, neutral_q;

	logic signed [7:0]            bal_pend_q, gain_pend_q, shut_pend_q;
	logic signed [7:0]            bal_pend_n, gain_pend_n, shut_pend_n;
	logic [4:0]                   iris_idx_q, iris_idx_n, iris_top;
	logic [7:0]                   focus_pos_q, focus_pos_n;
	logic [1:0]                   phase_q, phase_n;
	logic [kptc_pkg::CHAN_W-1:0]  iris_ch_q, focus_ch_q, gain_ch_q, shut_ch_q, bal_ch_q;
	logic [kptc_pkg::CHAN_W-1:0]  iris_ch_n, focus_ch_n, gain_ch_n, shut_ch_n, bal_ch_n;
	kptc_pkg::stick_t             bal_st, gain_st, shut_st;
	logic                         frame;
	logic [1:0]                   d_bal, d_gain, d_shut, d_iris, d_focus;

	kptc_pkg::out_word_t          res_q;
	logic                         res_v_q;

	assign advance   = v_s1 && (!res_v_q || out_ready);
	assign in_ready  = !v_s1 || advance;
	assign out_valid = res_v_q;
	assign out_word  = res_q;

	kptc_pin_filter u_filter (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.word    (word_s1),
		.filt    (filt)
	);

	assign d_bal   = filt.dirs[kptc_pkg::ENC_BALANCE];
	assign d_gain  = filt.dirs[kptc_pkg::ENC_GAIN];
	assign d_shut  = filt.dirs[kptc_pkg::ENC_SHUTTER];
	assign d_iris  = filt.dirs[kptc_pkg::ENC_IRIS];
	assign d_focus = filt.dirs[kptc_pkg::ENC_FOCUS];

	always_comb begin
		iris_top = (iris_last_q < kptc_pkg::IRIS_TOP_MAX) ? iris_last_q
				: kptc_pkg::IRIS_TOP_MAX;

		iris_idx_n = iris_idx_q;
		if (d_iris == kptc_pkg::DIR_CW) begin
			if (iris_idx_q < iris_top) iris_idx_n = iris_idx_q + 5'd1;
		end else if (d_iris == kptc_pkg::DIR_CCW) begin
			if (iris_idx_q != 5'd0) iris_idx_n = iris_idx_q - 5'd1;
		end

		focus_pos_n = focus_pos_q;
		if (d_focus == kptc_pkg::DIR_CW) begin
			if (focus_pos_q > focus_min_q) focus_pos_n = focus_pos_q - 8'd1;
		end else if (d_focus == kptc_pkg::DIR_CCW) begin
			if (focus_pos_q < focus_max_q) focus_pos_n = focus_pos_q + 8'd1;
		end

		bal_st  = kptc_pkg::stick_step(bal_ch_q, kptc_pkg::bump(bal_pend_q, d_bal),
				stick_high_q, stick_low_q, neutral_q);
		gain_st = kptc_pkg::stick_step(gain_ch_q, kptc_pkg::bump(gain_pend_q, d_gain),
				stick_high_q, stick_low_q, neutral_q);
		shut_st = kptc_pkg::stick_step(shut_ch_q, kptc_pkg::bump(shut_pend_q, d_shut),
				stick_high_q, stick_low_q, neutral_q);

		frame       = 1'b0;
		bal_pend_n  = kptc_pkg::bump(bal_pend_q, d_bal);
		gain_pend_n = kptc_pkg::bump(gain_pend_q, d_gain);
		shut_pend_n = kptc_pkg::bump(shut_pend_q, d_shut);
		iris_ch_n   = iris_ch_q;
		focus_ch_n  = focus_ch_q;
		gain_ch_n   = gain_ch_q;
		shut_ch_n   = shut_ch_q;
		bal_ch_n    = bal_ch_q;
		case (phase_q)
			kptc_pkg::PH_UPDATE: begin
				bal_pend_n  = bal_st.pend;
				gain_pend_n = gain_st.pend;
				shut_pend_n = shut_st.pend;
				bal_ch_n    = bal_st.chan;
				gain_ch_n   = gain_st.chan;
				shut_ch_n   = shut_st.chan;
				iris_ch_n   = {kptc_pkg::stop_entry(iris_idx_n), 3'b000};
				focus_ch_n  = {focus_pos_n, 3'b000};
			end
			kptc_pkg::PH_FRAME: frame = 1'b1;
			default: ;
		endcase

		case (phase_q)
			kptc_pkg::PH_UPDATE: phase_n = kptc_pkg::PH_FRAME;
			kptc_pkg::PH_FRAME:  phase_n = kptc_pkg::PH_REST;
			default:             phase_n = kptc_pkg::PH_UPDATE;
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= in_word;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focus_min_q  <= kptc_pkg::FOCUS_MIN_RST;
			focus_max_q  <= kptc_pkg::FOCUS_MAX_RST;
			iris_last_q  <= kptc_pkg::IRIS_LAST_RST;
			stick_high_q <= kptc_pkg::STICK_HIGH_RST;
			stick_low_q  <= kptc_pkg::STICK_LOW_RST;
			neutral_q    <= kptc_pkg::NEUTRAL_RST;
		end else if (cfg_en) begin
			case (cfg_addr)
				kptc_pkg::CFG_FOCUS_MIN:  focus_min_q  <= cfg_data[7:0];
				kptc_pkg::CFG_FOCUS_MAX:  focus_max_q  <= cfg_data[7:0];
				kptc_pkg::CFG_IRIS_LAST:  iris_last_q  <= cfg_data[4:0];
				kptc_pkg::CFG_STICK_HIGH: stick_high_q <= cfg_data;
				kptc_pkg::CFG_STICK_LOW:  stick_low_q  <= cfg_data;
				kptc_pkg::CFG_NEUTRAL:    neutral_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// camera state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bal_pend_q  <= '0;
			gain_pend_q <= '0;
			shut_pend_q <= '0;
			iris_idx_q  <= '0;
			focus_pos_q <= kptc_pkg::FOCUS_RESET;
			phase_q     <= kptc_pkg::PH_UPDATE;
			iris_ch_q   <= kptc_pkg::CHAN_RESET;
			focus_ch_q  <= kptc_pkg::CHAN_RESET;
			gain_ch_q   <= kptc_pkg::CHAN_RESET;
			shut_ch_q   <= kptc_pkg::CHAN_RESET;
			bal_ch_q    <= kptc_pkg::CHAN_RESET;
		end else if (advance) begin
			bal_pend_q  <= bal_pend_n;
			gain_pend_q <= gain_pend_n;
			shut_pend_q <= shut_pend_n;
			iris_idx_q  <= iris_idx_n;
			focus_pos_q <= focus_pos_n;
			phase_q     <= phase_n;
			iris_ch_q   <= iris_ch_n;
			focus_ch_q  <= focus_ch_n;
			gain_ch_q   <= gain_ch_n;
			shut_ch_q   <= shut_ch_n;
			bal_ch_q    <= bal_ch_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (advance) begin
			res_v_q <= 1'b1;
		end else if (out_ready) begin
			res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.pressed_mask  <= filt.pressed;
			res_q.step_dirs     <= filt.dirs;
			res_q.report_needed <= filt.report;
			res_q.frame_due     <= frame;
			res_q.iris_servo    <= iris_ch_n;
			res_q.focus_servo   <= focus_ch_n;
			res_q.gain_servo    <= gain_ch_n;
			res_q.shutter_servo <= shut_ch_n;
			res_q.balance_servo <= bal_ch_n;
		end
	end

endmodule

// ===== tb/kptc_tick_checker.sv =====
// Tick result checker: predicts each panel tick result and compares it with the block output.
`timescale 1ns / 100ps

module kptc_tick_checker
	import kptc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  in_word_t            in_word,
	input  logic                out_valid,
	input  logic                out_ready,
	input  out_word_t           out_word,
	input  logic                cfg_en,
	input  logic [CFG_AW-1:0]   cfg_addr,
	input  logic [CHAN_W-1:0]   cfg_data,
	output int                  fault_count,
	output int                  words_checked
);

	localparam int REPORT_LIMIT = 10;

	// f-stop positions; entries past the last stop park at the table floor
	localparam logic [7:0] FSTOP_TABLE [32] = '{
		8'd212, 8'd205, 8'd198, 8'd191, 8'd184, 8'd177, 8'd170, 8'd163,
		8'd156, 8'd149, 8'd142, 8'd135, 8'd128, 8'd121, 8'd115, 8'd107,
		8'd100, 8'd93,  8'd86,  8'd80,  8'd73,  8'd66,  8'd60,  8'd56,
		8'd44,  8'd44,  8'd44,  8'd44,  8'd44,  8'd44,  8'd44,  8'd44
	};

	// Register copies
	logic [7:0]        focus_min_cfg, focus_max_cfg;
	logic [4:0]        iris_last_cfg;
	logic [CHAN_W-1:0] stick_hi_cfg, stick_lo_cfg, neutral_cfg;

	// Panel state
	logic              primed;
	logic [2:0]        a_hist [NUM_ENCODERS];
	logic [2:0]        b_hist [NUM_ENCODERS];
	logic [1:0]        btn_state [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] last_pressed;
	int                balance_pend, gain_pend, shutter_pend;
	logic [4:0]        iris_idx;
	logic [7:0]        focus_pos;
	logic [1:0]        tick_phase;
	logic [CHAN_W-1:0] iris_ch, focus_ch, gain_ch, shutter_ch, balance_ch;

	out_word_t tick_results_due [$];
	int        faults, checked;

	function automatic int count_step(input int v, input logic [1:0] d);
		if (d == DIR_CW && v < int'(PEND_MAX))
			return v + 1;
		if (d == DIR_CCW && v > int'(PEND_MIN))
			return v - 1;
		return v;
	endfunction

	task automatic stick_pulse(inout logic [CHAN_W-1:0] ch, inout int pend);
		if (ch == neutral_cfg) begin
			if (pend > 0) begin
				ch = stick_hi_cfg;
				pend = pend - 1;
			end else if (pend < 0) begin
				ch = stick_lo_cfg;
				pend = pend + 1;
			end
		end else begin
			ch = neutral_cfg;
		end
	endtask

	task automatic run_tick(input in_word_t w, output out_word_t r);
		logic [1:0]             dir [NUM_ENCODERS];
		logic [2:0]             ha, hb;
		logic [1:0]             s;
		logic                   sw;
		logic [NUM_BUTTONS-1:0] pressed;
		logic                   stepped;
		logic [4:0]             top;
		r = '0;
		stepped = 1'b0;
		for (int i = 0; i < NUM_ENCODERS; i++) begin
			// first tick after reset: fill the history so no step shows
			if (!primed) begin
				a_hist[i] = {3{w.enc_a_pins[i]}};
				b_hist[i] = {3{w.enc_b_pins[i]}};
			end
			ha = {a_hist[i][1:0], w.enc_a_pins[i]};
			hb = {b_hist[i][1:0], w.enc_b_pins[i]};
			a_hist[i] = ha;
			b_hist[i] = hb;
			dir[i] = DIR_NONE;
			if (ha == 3'b100)
				dir[i] = hb[1] ? DIR_CW : DIR_CCW;
			else if (ha == 3'b011)
				dir[i] = hb[1] ? DIR_CCW : DIR_CW;
			r.step_dirs[2*i +: 2] = dir[i];
			if (dir[i] != DIR_NONE)
				stepped = 1'b1;
		end
		primed = 1'b1;

		pressed = '0;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			sw = w.button_pins[i];
			case (btn_state[i])
				DB_IDLE: s = sw ? DB_ARM : DB_IDLE;
				DB_ARM:  s = sw ? DB_HELD : DB_IDLE;
				DB_HELD: s = sw ? DB_HELD : DB_REL;
				default: s = sw ? DB_HELD : DB_IDLE;
			endcase
			btn_state[i] = s;
			pressed[i] = (s == DB_HELD || s == DB_REL);
		end
		if (pressed != last_pressed)
			stepped = 1'b1;
		last_pressed = pressed;

		balance_pend = count_step(balance_pend, dir[ENC_BALANCE]);
		gain_pend = count_step(gain_pend, dir[ENC_GAIN]);
		shutter_pend = count_step(shutter_pend, dir[ENC_SHUTTER]);

		top = (iris_last_cfg < IRIS_TOP_MAX) ? iris_last_cfg : IRIS_TOP_MAX;
		if (dir[ENC_IRIS] == DIR_CW) begin
			if (iris_idx < top)
				iris_idx = iris_idx + 5'd1;
		end else if (dir[ENC_IRIS] == DIR_CCW) begin
			if (iris_idx > 5'd0)
				iris_idx = iris_idx - 5'd1;
		end

		// each bound only limits its own direction, even when crossed
		if (dir[ENC_FOCUS] == DIR_CW) begin
			if (focus_pos > focus_min_cfg)
				focus_pos = focus_pos - 8'd1;
		end else if (dir[ENC_FOCUS] == DIR_CCW) begin
			if (focus_pos < focus_max_cfg)
				focus_pos = focus_pos + 8'd1;
		end

		if (tick_phase == PH_UPDATE) begin
			stick_pulse(balance_ch, balance_pend);
			stick_pulse(gain_ch, gain_pend);
			stick_pulse(shutter_ch, shutter_pend);
			iris_ch = {FSTOP_TABLE[iris_idx], 3'b000};
			focus_ch = {focus_pos, 3'b000};
		end else if (tick_phase == PH_FRAME) begin
			r.frame_due = 1'b1;
		end
		tick_phase = (tick_phase == PH_REST) ? PH_UPDATE : tick_phase + 2'd1;

		r.pressed_mask = pressed;
		r.report_needed = stepped;
		r.iris_servo = iris_ch;
		r.focus_servo = focus_ch;
		r.gain_servo = gain_ch;
		r.shutter_servo = shutter_ch;
		r.balance_servo = balance_ch;
	endtask

	task automatic match_field(input string fld, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			faults++;
			if (faults <= REPORT_LIMIT)
				$display("tick result %0d: %s expected 0x%0h got 0x%0h",
					checked, fld, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_word_t want, got;
		out_word_t fresh;
		if (!arst_n) begin
			focus_min_cfg = FOCUS_MIN_RST;
			focus_max_cfg = FOCUS_MAX_RST;
			iris_last_cfg = IRIS_LAST_RST;
			stick_hi_cfg = STICK_HIGH_RST;
			stick_lo_cfg = STICK_LOW_RST;
			neutral_cfg = NEUTRAL_RST;
			primed = 1'b0;
			for (int i = 0; i < NUM_ENCODERS; i++) begin
				a_hist[i] = '0;
				b_hist[i] = '0;
			end
			for (int i = 0; i < NUM_BUTTONS; i++)
				btn_state[i] = DB_IDLE;
			last_pressed = '0;
			balance_pend = 0;
			gain_pend = 0;
			shutter_pend = 0;
			iris_idx = '0;
			focus_pos = FOCUS_RESET;
			tick_phase = PH_UPDATE;
			iris_ch = CHAN_RESET;
			focus_ch = CHAN_RESET;
			gain_ch = CHAN_RESET;
			shutter_ch = CHAN_RESET;
			balance_ch = CHAN_RESET;
			tick_results_due.delete();
			faults = 0;
			checked = 0;
		end else begin
			if (cfg_en) begin
				case (cfg_addr)
					CFG_FOCUS_MIN:  focus_min_cfg = cfg_data[7:0];
					CFG_FOCUS_MAX:  focus_max_cfg = cfg_data[7:0];
					CFG_IRIS_LAST:  iris_last_cfg = cfg_data[4:0];
					CFG_STICK_HIGH: stick_hi_cfg = cfg_data;
					CFG_STICK_LOW:  stick_lo_cfg = cfg_data;
					CFG_NEUTRAL:    neutral_cfg = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				got = out_word;
				if (tick_results_due.size() == 0) begin
					faults++;
					if (faults <= REPORT_LIMIT)
						$display("tick result with none pending: expected none got 0x%0h",
							got);
				end else begin
					want = tick_results_due.pop_front();
					match_field("pressed_mask", 32'(want.pressed_mask),
						32'(got.pressed_mask));
					match_field("step_dirs", 32'(want.step_dirs), 32'(got.step_dirs));
					match_field("report_needed", 32'(want.report_needed),
						32'(got.report_needed));
					match_field("frame_due", 32'(want.frame_due), 32'(got.frame_due));
					match_field("iris_servo", 32'(want.iris_servo), 32'(got.iris_servo));
					match_field("focus_servo", 32'(want.focus_servo),
						32'(got.focus_servo));
					match_field("gain_servo", 32'(want.gain_servo), 32'(got.gain_servo));
					match_field("shutter_servo", 32'(want.shutter_servo),
						32'(got.shutter_servo));
					match_field("balance_servo", 32'(want.balance_servo),
						32'(got.balance_servo));
					checked++;
				end
			end
			if (in_valid && in_ready) begin
				run_tick(in_word, fresh);
				tick_results_due.push_back(fresh);
			end
		end
		fault_count <= faults;
		words_checked <= checked;
	end

endmodule

// ===== tb/testbench.sv =====
// Testbench top: drives panel ticks, register writes and output stalls, and gives the verdict.
`timescale 1ns / 100ps

module testbench;
	import kptc_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int TICK_TARGET = 1400;

	typedef enum int {
		SPIN_IDLE,
		SPIN_FWD,
		SPIN_BACK,
		SPIN_FAST_CW,
		SPIN_FAST_CCW,
		SPIN_NOISE
	} spin_mode_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	in_word_t            in_word = '0;
	logic                out_ready = 1'b0;
	logic                cfg_en = 1'b0;
	logic [CFG_AW-1:0]   cfg_addr = '0;
	logic [CHAN_W-1:0]   cfg_data = '0;
	logic                in_ready;
	logic                out_valid;
	out_word_t           out_word;
	int                  fault_count;
	int                  words_checked;

	int                  cycle_count = 0;
	int                  ticks_sent = 0;
	int                  send_calm = 0;
	int                  ready_calm = 0;
	int                  ready_stall = 0;

	spin_mode_t          enc_mode [NUM_ENCODERS];
	logic [1:0]          enc_quad [NUM_ENCODERS];
	logic [1:0]          enc_ctr [NUM_ENCODERS];
	int                  enc_dwell [NUM_ENCODERS];
	logic                btn_level [NUM_BUTTONS];
	int                  btn_left [NUM_BUTTONS];

	knob_panel_tick_controller_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.cfg_en    (cfg_en),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data)
	);

	kptc_tick_checker tick_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_word       (in_word),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_word      (out_word),
		.cfg_en        (cfg_en),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data),
		.fault_count   (fault_count),
		.words_checked (words_checked)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[knob_panel_tick_controller_top] ERROR");
			$finish;
		end
	end

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 93)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Result side: random stalls with calm stretches between
	always @(posedge clk) begin
		if (ready_stall > 0) begin
			out_ready <= 1'b0;
			ready_stall--;
		end else begin
			out_ready <= 1'b1;
			if (ready_calm > 0)
				ready_calm--;
			else if ($urandom_range(0, 99) < 6)
				ready_calm = $urandom_range(30, 150);
			else if ($urandom_range(0, 99) < 35)
				ready_stall = pick_gap();
		end
	end

	function automatic in_word_t pins(input logic [NUM_ENCODERS-1:0] a,
			input logic [NUM_ENCODERS-1:0] b, input logic [NUM_BUTTONS-1:0] btn);
		in_word_t w;
		w.enc_a_pins = a;
		w.enc_b_pins = b;
		w.button_pins = btn;
		return w;
	endfunction

	// Gray sequence A,B: 00 10 11 01 reads clockwise going forward
	function automatic logic [1:0] quad_pins(input logic [1:0] q);
		case (q)
			2'd0: return 2'b00;
			2'd1: return 2'b10;
			2'd2: return 2'b11;
			default: return 2'b01;
		endcase
	endfunction

	task automatic push_tick(input in_word_t w);
		int gap;
		if (send_calm > 0) begin
			send_calm--;
			gap = 0;
		end else begin
			if ($urandom_range(0, 99) < 5)
				send_calm = $urandom_range(30, 150);
			gap = ($urandom_range(0, 99) < 55) ? 0 : pick_gap();
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		ticks_sent++;
	endtask

	// Drop valid and wait for every pending tick result
	task automatic settle();
		in_valid <= 1'b0;
		while (words_checked != ticks_sent)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_AW-1:0] addr, input logic [CHAN_W-1:0] data);
		cfg_en <= 1'b1;
		cfg_addr <= addr;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic program_panel(input logic [7:0] fmin, input logic [7:0] fmax,
			input logic [4:0] ilast, input logic [CHAN_W-1:0] hi,
			input logic [CHAN_W-1:0] lo, input logic [CHAN_W-1:0] neu);
		settle();
		put_reg(CFG_FOCUS_MIN, CHAN_W'(fmin));
		put_reg(CFG_FOCUS_MAX, CHAN_W'(fmax));
		put_reg(CFG_IRIS_LAST, CHAN_W'(ilast));
		put_reg(CFG_STICK_HIGH, hi);
		put_reg(CFG_STICK_LOW, lo);
		put_reg(CFG_NEUTRAL, neu);
		cfg_en <= 1'b0;
	endtask

	function automatic int unsigned bound_pick(input int unsigned maxv);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 20)
			return 0;
		if (r < 40)
			return maxv;
		return $urandom_range(0, maxv);
	endfunction

	task automatic set_modes(input spin_mode_t m);
		for (int e = 0; e < NUM_ENCODERS; e++)
			enc_mode[e] = m;
	endtask

	task automatic play_burst(input int ticks, input int noise_pct);
		in_word_t   w;
		logic [1:0] ab;
		int         k;
		for (int t = 0; t < ticks; t++) begin
			for (int e = 0; e < NUM_ENCODERS; e++) begin
				case (enc_mode[e])
					SPIN_FWD, SPIN_BACK: begin
						if (enc_dwell[e] > 0) begin
							enc_dwell[e]--;
						end else begin
							enc_quad[e] = (enc_mode[e] == SPIN_FWD) ?
								enc_quad[e] + 2'd1 : enc_quad[e] - 2'd1;
							enc_dwell[e] = $urandom_range(1, 3);
						end
						ab = quad_pins(enc_quad[e]);
					end
					SPIN_FAST_CW, SPIN_FAST_CCW: begin
						// A toggles every two ticks; B picks the direction
						enc_ctr[e] = enc_ctr[e] + 2'd1;
						ab[1] = enc_ctr[e][1];
						ab[0] = (enc_mode[e] == SPIN_FAST_CW) ? ~ab[1] : ab[1];
					end
					SPIN_NOISE: ab = 2'($urandom_range(0, 3));
					default: ab = quad_pins(enc_quad[e]);
				endcase
				w.enc_a_pins[e] = ab[1];
				w.enc_b_pins[e] = ab[0];
			end
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				if (btn_left[i] > 0) begin
					btn_left[i]--;
				end else begin
					btn_level[i] = ~btn_level[i];
					// zero hold makes a one-tick bounce
					btn_left[i] = ($urandom_range(0, 99) < 15) ? 0 : $urandom_range(2, 12);
				end
				w.button_pins[i] = btn_level[i];
			end
			if ($urandom_range(0, 99) < noise_pct) begin
				k = $urandom_range(0, NUM_ENCODERS - 1);
				w.enc_a_pins[k] = ~w.enc_a_pins[k];
				k = $urandom_range(0, NUM_ENCODERS - 1);
				w.enc_b_pins[k] = ~w.enc_b_pins[k];
				k = $urandom_range(0, NUM_BUTTONS - 1);
				w.button_pins[k] = ~w.button_pins[k];
			end
			push_tick(w);
		end
	endtask

	initial begin
		logic [CHAN_W-1:0] hi, lo, neu;
		for (int e = 0; e < NUM_ENCODERS; e++) begin
			enc_mode[e] = SPIN_IDLE;
			enc_quad[e] = '0;
			enc_ctr[e] = '0;
			enc_dwell[e] = 0;
		end
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			btn_level[i] = 1'b0;
			btn_left[i] = $urandom_range(0, 6);
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: priming tick, both edge kinds with both B levels, debouncer paths
		push_tick(pins(5'h1F, 5'h00, 7'h00));
		push_tick(pins(5'h00, 5'h1F, 7'h7F));
		push_tick(pins(5'h00, 5'h1F, 7'h7F));
		push_tick(pins(5'h1F, 5'h00, 7'h00));
		push_tick(pins(5'h1F, 5'h00, 7'h7F));
		push_tick(pins(5'h00, 5'h00, 7'h00));
		push_tick(pins(5'h00, 5'h00, 7'h00));
		push_tick(pins(5'h1F, 5'h1F, 7'h7F));
		push_tick(pins(5'h1F, 5'h1F, 7'h00));
		push_tick(pins(5'h15, 5'h0A, 7'h55));
		push_tick(pins(5'h0A, 5'h15, 7'h55));
		push_tick(pins(5'h0A, 5'h15, 7'h2A));
		push_tick(pins(5'h15, 5'h1F, 7'h2A));
		push_tick(pins(5'h15, 5'h00, 7'h2A));
		push_tick(pins(5'h00, 5'h1F, 7'h00));
		push_tick(pins(5'h00, 5'h00, 7'h00));

		// Wide bounds: drive the counts into positive saturation and iris to the top
		program_panel(8'd0, 8'd255, 5'd24, 11'd2047, 11'd0, 11'd1024);
		set_modes(SPIN_FAST_CW);
		play_burst(400, 0);

		// Iris top below the index, crossed focus bounds, neutral off the current channels
		program_panel(8'd200, 8'd50, 5'd3, 11'd1024, 11'd1000, 11'd1000);
		play_burst(30, 0);
		set_modes(SPIN_FAST_CCW);
		play_burst(450, 0);

		// Iris top beyond the table, neutral equal to the stick-high value
		program_panel(8'd44, 8'd212, 5'd31, 11'd1696, 11'd352, 11'd1696);
		set_modes(SPIN_FWD);
		play_burst(40, 2);
		set_modes(SPIN_BACK);
		play_burst(40, 2);

		while (ticks_sent < TICK_TARGET) begin
			if ($urandom_range(0, 2) == 0) begin
				hi = CHAN_W'(bound_pick(2047));
				lo = CHAN_W'(bound_pick(2047));
				neu = CHAN_W'(bound_pick(2047));
				if ($urandom_range(0, 4) == 0)
					neu = $urandom_range(0, 1) ? hi : lo;
				program_panel(8'(bound_pick(255)), 8'(bound_pick(255)),
					5'(bound_pick(31)), hi, lo, neu);
			end
			for (int e = 0; e < NUM_ENCODERS; e++)
				enc_mode[e] = spin_mode_t'($urandom_range(0, 5));
			play_burst($urandom_range(10, 50), $urandom_range(0, 8));
		end

		settle();
		if (fault_count == 0)
			$display("[knob_panel_tick_controller_top] OK");
		else
			$display("[knob_panel_tick_controller_top] ERROR");
		$finish;
	end

endmodule

// ===== knob_panel_tick_controller_top.f =====
design/kptc_pkg.sv
design/kptc_pin_filter.sv
design/knob_panel_tick_controller_top.sv
tb/kptc_tick_checker.sv
tb/testbench.sv
